// File: design/rgbmon_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgbmon_pkg;

   localparam int CHANNELS = 3;

   // command carried by each input word
   typedef enum logic [2:0] {
      MODE_SET_DUTY  = 3'd0,
      MODE_MEASURE   = 3'd1,
      MODE_RESET_DET = 3'd2,
      MODE_SLEEP     = 3'd3,
      MODE_INIT      = 3'd4
   } mode_type;

   // per channel status
   typedef enum logic [1:0] {
      ST_INIT   = 2'd0,
      ST_NORMAL = 2'd1,
      ST_OPEN   = 2'd2,
      ST_SHORT  = 2'd3
   } status_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_CAL_MODE   = 3'd0,
      REG_PWM_PERIOD = 3'd1,
      REG_DUTY_MIN   = 3'd2,
      REG_OPEN_LIMIT = 3'd3,
      REG_SHORT_LIM  = 3'd4,
      REG_CONFIRM    = 3'd5
   } reg_index_type;

   // calibration selector codes
   localparam logic [2:0] CAL_NONE  = 3'd0;
   localparam logic [2:0] CAL_RED   = 3'd1;
   localparam logic [2:0] CAL_BLUE  = 3'd3;
   localparam logic [2:0] CAL_LIMIT = 3'd4;

   // period / 10 by reciprocal, exact for any 16-bit period
   localparam logic [15:0] DIV10_MULT  = 16'd52429;
   localparam int          DIV10_SHIFT = 19;

   // reset values of the configuration registers
   localparam logic [15:0]        RST_PERIOD   = 16'd2000;
   localparam logic [15:0]        RST_TOP      = 16'd1999;
   localparam logic [15:0]        RST_CAL_DUTY = 16'd800;
   localparam logic [15:0]        RST_DUTY_MIN = 16'd480;
   localparam logic signed [15:0] RST_OPEN     = 16'sd6999;
   localparam logic signed [15:0] RST_SHORT    = 16'sd400;
   localparam logic [14:0]        RST_CONFIRM  = 15'd100;

   typedef struct packed {
      logic [15:0]        period;
      logic [15:0]        duty_top;
      logic [15:0]        cal_duty;
      logic [15:0]        duty_min;
      logic signed [15:0] open_limit;
      logic signed [15:0] short_limit;
      logic [14:0]        confirm;
   } cfg_type;

   // control shared by all lanes and the merge stage
   typedef struct packed {
      logic     accept;
      mode_type mode;
      logic     cal_on;
      logic     mask_any;
   } lane_ctrl_type;

   // next-state view of one lane
   typedef struct packed {
      logic [15:0] duty;
      logic        mask;
      status_type  state;
   } lane_next_type;

endpackage

`default_nettype wire

// File: design/rgbmon_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbmon_lane (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire rgbmon_pkg::lane_ctrl_type ctrl,
   input  wire rgbmon_pkg::cfg_type       cfg,
   input  wire logic                      cal_sel,
   input  wire logic [15:0]               duty_req,
   input  wire logic signed [15:0]        volt,
   input  wire logic                      sample_ok,
   output rgbmon_pkg::lane_next_type      nxt,
   output logic                           mask
);

   logic [15:0]            duty_ff, duty_in;
   logic                   mask_ff, mask_in;
   rgbmon_pkg::status_type state_ff, state_in;
   logic [14:0]            cnt_ff, cnt_in;

   logic [15:0]            req_duty;
   logic [15:0]            applied;
   rgbmon_pkg::status_type reading;

   always_comb begin
      // calibration override, sleep forces zero, then clamp below the period
      if (ctrl.cal_on) begin
         req_duty = cal_sel ? cfg.cal_duty : 16'd0;
      end else if (ctrl.mode == rgbmon_pkg::MODE_SLEEP) begin
         req_duty = 16'd0;
      end else begin
         req_duty = duty_req;
      end
      applied = (req_duty < cfg.period) ? req_duty : cfg.duty_top;

      if (volt >= cfg.open_limit) begin
         reading = rgbmon_pkg::ST_OPEN;
      end else if (volt < cfg.short_limit) begin
         reading = rgbmon_pkg::ST_SHORT;
      end else begin
         reading = rgbmon_pkg::ST_NORMAL;
      end

      duty_in  = duty_ff;
      mask_in  = mask_ff;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      if (ctrl.accept) begin
         case (ctrl.mode)
            rgbmon_pkg::MODE_SET_DUTY: begin
               duty_in = applied;
               mask_in = (applied > cfg.duty_min);
            end
            rgbmon_pkg::MODE_MEASURE: begin
               if (ctrl.mask_any && mask_ff && sample_ok) begin
                  if ((reading != rgbmon_pkg::ST_NORMAL) && (cnt_ff != 15'd0)) begin
                     cnt_in = cnt_ff - 15'd1;
                  end else begin
                     state_in = reading;
                     cnt_in   = cfg.confirm;
                  end
               end
            end
            rgbmon_pkg::MODE_RESET_DET: begin
               cnt_in = cfg.confirm;
               if ((state_ff == rgbmon_pkg::ST_OPEN) || (state_ff == rgbmon_pkg::ST_SHORT)) begin
                  state_in = rgbmon_pkg::ST_INIT;
               end
            end
            rgbmon_pkg::MODE_SLEEP: begin
               duty_in  = applied;
               mask_in  = (applied > cfg.duty_min);
               state_in = rgbmon_pkg::ST_INIT;
            end
            rgbmon_pkg::MODE_INIT: begin
               mask_in  = 1'b0;
               state_in = rgbmon_pkg::ST_INIT;
               cnt_in   = cfg.confirm;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff  <= 16'd0;
         mask_ff  <= 1'b0;
         state_ff <= rgbmon_pkg::ST_INIT;
         cnt_ff   <= rgbmon_pkg::RST_CONFIRM;
      end else begin
         duty_ff  <= duty_in;
         mask_ff  <= mask_in;
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign nxt.duty  = duty_in;
   assign nxt.mask  = mask_in;
   assign nxt.state = state_in;
   assign mask      = mask_ff;

endmodule

`default_nettype wire

// File: design/rgbmon_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbmon_merge (
   input  wire logic                                                  clock,
   input  wire logic                                                  reset,
   input  wire rgbmon_pkg::lane_ctrl_type                             ctrl,
   input  wire rgbmon_pkg::lane_next_type [rgbmon_pkg::CHANNELS-1:0] lane_nxt,
   input  wire logic [rgbmon_pkg::CHANNELS-1:0]                       lane_mask,
   input  wire logic                                                  rsp_tready,
   output logic                                                       rsp_tvalid,
   output logic [63:0]                                                rsp_tdata
);

   logic        latch_ff, latch_in;
   logic        driver_ff, driver_in;
   logic        valid_ff, valid_in;
   logic [63:0] data_ff, data_in;
   logic        any_fault;
   logic        adc_start;
   logic [2:0]  adc_mask;

   always_comb begin
      any_fault = 1'b0;
      for (int i = 0; i < rgbmon_pkg::CHANNELS; i++) begin
         if ((lane_nxt[i].state == rgbmon_pkg::ST_OPEN) ||
             (lane_nxt[i].state == rgbmon_pkg::ST_SHORT)) begin
            any_fault = 1'b1;
         end
      end

      latch_in  = latch_ff;
      driver_in = driver_ff;
      adc_start = 1'b0;
      adc_mask  = 3'd0;
      case (ctrl.mode)
         rgbmon_pkg::MODE_MEASURE: begin
            adc_start = 1'b1;
            if (ctrl.mask_any) begin
               latch_in = any_fault;
               adc_mask = lane_mask;
            end
         end
         rgbmon_pkg::MODE_RESET_DET: begin
            latch_in = 1'b0;
         end
         rgbmon_pkg::MODE_SLEEP: begin
            driver_in = 1'b0;
         end
         rgbmon_pkg::MODE_INIT: begin
            latch_in  = 1'b0;
            driver_in = 1'b1;
         end
         default: begin
         end
      endcase

      data_in = {1'b0, driver_in, adc_mask, adc_start, latch_in,
                 lane_nxt[2].state, lane_nxt[1].state, lane_nxt[0].state,
                 lane_nxt[2].mask, lane_nxt[1].mask, lane_nxt[0].mask,
                 lane_nxt[2].duty, lane_nxt[1].duty, lane_nxt[0].duty};

      if (ctrl.accept) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff  <= 1'b0;
         driver_ff <= 1'b1;
         valid_ff  <= 1'b0;
      end else if (ctrl.accept) begin
         latch_ff  <= latch_in;
         driver_ff <= driver_in;
         valid_ff  <= valid_in;
      end else begin
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

`default_nettype wire

// File: design/rgb_led_duty_and_fault_monitor.sv
// timing: a result appears on rsp in the cycle after its request word is accepted
// throughput: one word per cycle while rsp_tready stays high; the three channel lanes
//   and merge stage are combinational; the output register refills as it drains
// reset: synchronous, active high; clears duties, masks, statuses and the error latch,
//   loads the register defaults, reloads the confirm counters and enables the driver
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_duty_and_fault_monitor (
   input  wire logic         clock,
   input  wire logic         reset,
   // request: command plus per-channel duties, voltages and sample flags
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata, low bit up: duty_red, duty_green, duty_blue, volt_red, volt_green,
   // volt_blue, sample_ok_red, sample_ok_green, sample_ok_blue, zero fill
   input  wire logic [103:0] req_tdata,
   // tuser: mode
   input  wire logic [2:0]   req_tuser,
   // response: one word per request
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata, low bit up: out_duty_red, out_duty_green, out_duty_blue, detect_mask,
   // state_red, state_green, state_blue, fault_flag, adc_start, adc_mask,
   // driver_on, zero fill
   output logic [63:0]       rsp_tdata,
   // configuration write port
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_addr,
   input  wire logic [15:0]  csr_wdata
);

   rgbmon_pkg::cfg_type       cfg_ff, cfg_in;
   logic [2:0]                cal_mode_ff, cal_mode_in;
   logic [31:0]               div_prod;
   rgbmon_pkg::lane_ctrl_type ctrl;

   rgbmon_pkg::lane_next_type [rgbmon_pkg::CHANNELS-1:0] lane_nxt;
   logic [rgbmon_pkg::CHANNELS-1:0]                      lane_mask;

   // ---------------------------------------------------------------------------
   // configuration registers
   // derived values (period - 1 and the calibration duty) are computed at write
   // time so the lanes see only registered operands
   // ---------------------------------------------------------------------------
   always_comb begin
      cfg_in      = cfg_ff;
      cal_mode_in = cal_mode_ff;
      // period / 10 by multiply and shift
      div_prod    = 32'(csr_wdata) * 32'(rgbmon_pkg::DIV10_MULT);
      if (csr_we) begin
         case (csr_addr)
            rgbmon_pkg::REG_CAL_MODE: begin
               // codes above blue-plus-one are dropped, old selection stays
               if (csr_wdata[2:0] <= rgbmon_pkg::CAL_LIMIT) begin
                  cal_mode_in = csr_wdata[2:0];
               end
            end
            rgbmon_pkg::REG_PWM_PERIOD: begin
               cfg_in.period   = csr_wdata;
               cfg_in.duty_top = (csr_wdata == 16'd0) ? 16'd0 : csr_wdata - 16'd1;
               cfg_in.cal_duty = {1'b0, div_prod[31:rgbmon_pkg::DIV10_SHIFT], 2'b00};
            end
            rgbmon_pkg::REG_DUTY_MIN: begin
               cfg_in.duty_min = csr_wdata;
            end
            rgbmon_pkg::REG_OPEN_LIMIT: begin
               cfg_in.open_limit = csr_wdata;
            end
            rgbmon_pkg::REG_SHORT_LIM: begin
               cfg_in.short_limit = csr_wdata;
            end
            rgbmon_pkg::REG_CONFIRM: begin
               cfg_in.confirm = csr_wdata[14:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_mode_ff        <= rgbmon_pkg::CAL_NONE;
         cfg_ff.period      <= rgbmon_pkg::RST_PERIOD;
         cfg_ff.duty_top    <= rgbmon_pkg::RST_TOP;
         cfg_ff.cal_duty    <= rgbmon_pkg::RST_CAL_DUTY;
         cfg_ff.duty_min    <= rgbmon_pkg::RST_DUTY_MIN;
         cfg_ff.open_limit  <= rgbmon_pkg::RST_OPEN;
         cfg_ff.short_limit <= rgbmon_pkg::RST_SHORT;
         cfg_ff.confirm     <= rgbmon_pkg::RST_CONFIRM;
      end else begin
         cal_mode_ff <= cal_mode_in;
         cfg_ff      <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------------
   // handshake: take a new word whenever the output register is empty or
   // is being drained in this same cycle
   // ---------------------------------------------------------------------------
   assign req_tready    = !rsp_tvalid || rsp_tready;
   assign ctrl.accept   = req_tvalid && req_tready;
   assign ctrl.mode     = rgbmon_pkg::mode_type'(req_tuser);
   assign ctrl.cal_on   = (cal_mode_ff >= rgbmon_pkg::CAL_RED) &&
                          (cal_mode_ff <= rgbmon_pkg::CAL_BLUE);
   // measure only judges readings and updates the latch when at least one channel is marked
   assign ctrl.mask_any = |lane_mask;

   // ---------------------------------------------------------------------------
   // one lane per color: duty clamp, detect mark, fault judge and confirm counter
   // ---------------------------------------------------------------------------
   for (genvar g = 0; g < rgbmon_pkg::CHANNELS; g++) begin : g_lane
      rgbmon_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .cfg       (cfg_ff),
         .cal_sel   (cal_mode_ff == 3'(g + 1)),
         .duty_req  (req_tdata[g*16 +: 16]),
         .volt      (req_tdata[48 + g*16 +: 16]),
         .sample_ok (req_tdata[96 + g]),
         .nxt       (lane_nxt[g]),
         .mask      (lane_mask[g])
      );
   end

   // ---------------------------------------------------------------------------
   // merge: error latch, driver enable, adc request and the response register
   // ---------------------------------------------------------------------------
   rgbmon_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .lane_nxt   (lane_nxt),
      .lane_mask  (lane_mask),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: design/rgbmon_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbmon_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [2:0]   req_tuser,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [63:0]  rsp_tdata
);

   logic req_word;
   assign req_word = req_tvalid && req_tready;

   // a pending response word is not dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response word dropped while stalled");

   // no response without a request
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !req_word |=> !rsp_tvalid)
      else $error("response word without request");

   // a measure request gives a response with the adc start set
   a_measure_adc: assert property (@(posedge clock) disable iff (reset)
      req_word && (req_tuser == rgbmon_pkg::MODE_MEASURE) |=> rsp_tvalid && rsp_tdata[58])
      else $error("measure response missing adc start");

   // any other request gives no adc request at all
   a_other_adc: assert property (@(posedge clock) disable iff (reset)
      req_word && (req_tuser != rgbmon_pkg::MODE_MEASURE)
      |=> rsp_tvalid && !rsp_tdata[58] && (rsp_tdata[61:59] == 3'd0))
      else $error("adc request outside measure");

   // sleep turns the driver off and returns every status to init
   a_sleep: assert property (@(posedge clock) disable iff (reset)
      req_word && (req_tuser == rgbmon_pkg::MODE_SLEEP)
      |=> !rsp_tdata[62] && (rsp_tdata[56:51] == 6'd0))
      else $error("sleep response not powered down");

endmodule

bind rgb_led_duty_and_fault_monitor rgbmon_checker u_rgbmon_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: bench/rgb_led_duty_and_fault_monitor_tb.sv
`timescale 1ns / 1ps

module rgb_led_duty_and_fault_monitor_tb;
   import rgbmon_pkg::*;

   // watchdog: this long with no handshake on either side means the block is stuck
   localparam int         IDLE_LIMIT    = 600;
   localparam int         MAX_GAP       = 18;
   localparam logic [2:0] CAL_GREEN     = 3'd2;
   // register indexes the block does not decode
   localparam logic [2:0] ADDR_SPARE_LO = 3'd6;
   localparam logic [2:0] ADDR_SPARE_HI = 3'd7;
   // command codes with no function
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   // request word, last field in the lowest bits
   typedef struct packed {
      logic [4:0]       fill;
      logic [2:0]       sample_ok;  // bit0 red
      logic [2:0][15:0] volt;       // [0] red
      logic [2:0][15:0] duty;       // [0] red
   } req_word_type;

   // status word, last field in the lowest bits
   typedef struct packed {
      logic             fill;
      logic             driver_on;
      logic [2:0]       adc_mask;
      logic             adc_start;
      logic             fault_flag;
      logic [2:0][1:0]  state;
      logic [2:0]       detect_mask;
      logic [2:0][15:0] duty;
   } status_word_type;

   // tracks duties, masks and fault confirmation, one status word per command
   class rgb_monitor_scoreboard;
      logic [2:0]         cal_sel;
      logic [15:0]        period;
      logic [15:0]        duty_min;
      logic signed [15:0] open_lim;
      logic signed [15:0] short_lim;
      logic [14:0]        confirm_load;
      logic [15:0]        duty [3];
      logic [2:0]         mask;
      status_type         status [3];
      logic [14:0]        countdown [3];
      logic               latch;
      logic               driver;
      status_word_type    words_due [$];
      int                 mismatches;

      function new();
         cal_sel      = CAL_NONE;
         period       = RST_PERIOD;
         duty_min     = RST_DUTY_MIN;
         open_lim     = RST_OPEN;
         short_lim    = RST_SHORT;
         confirm_load = RST_CONFIRM;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            duty[ch]      = '0;
            status[ch]    = ST_INIT;
            countdown[ch] = RST_CONFIRM;
         end
         mask       = '0;
         latch      = 1'b0;
         driver     = 1'b1;
         mismatches = 0;
      endfunction

      function void write_register(logic [2:0] addr, logic [15:0] value);
         case (addr)
            REG_CAL_MODE:   if (value[2:0] <= CAL_LIMIT) cal_sel = value[2:0];
            REG_PWM_PERIOD: period = value;
            REG_DUTY_MIN:   duty_min = value;
            REG_OPEN_LIMIT: open_lim = value;
            REG_SHORT_LIM:  short_lim = value;
            REG_CONFIRM:    confirm_load = value[14:0];
            default: ;
         endcase
      endfunction

      // calibration override, clamp below the period, then mark channels
      function void apply_duties(logic [2:0][15:0] req);
         int cal_duty;
         int top;
         int want;
         cal_duty = (int'(period) / 10) * 4;
         top      = (period == 0) ? 0 : int'(period) - 1;
         mask     = '0;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            if (cal_sel >= CAL_RED && cal_sel <= CAL_BLUE)
               want = (ch == int'(cal_sel) - 1) ? cal_duty : 0;
            else
               want = int'(req[ch]);
            duty[ch] = (want < int'(period)) ? want[15:0] : top[15:0];
            if (duty[ch] > duty_min) mask[ch] = 1'b1;
         end
      endfunction

      function void judge_reading(int ch, logic signed [15:0] mv);
         status_type verdict;
         if (mv >= open_lim)
            verdict = ST_OPEN;
         else if (mv < short_lim)
            verdict = ST_SHORT;
         else
            verdict = ST_NORMAL;
         if (verdict != ST_NORMAL && countdown[ch] != 0) begin
            countdown[ch] = countdown[ch] - 1'b1;
         end else begin
            status[ch]    = verdict;
            countdown[ch] = confirm_load;
         end
      endfunction

      function void note_command(logic [2:0] mode, req_word_type w);
         status_word_type e;
         logic            any_fault;
         e = '0;
         case (mode)
            MODE_SET_DUTY: apply_duties(w.duty);
            MODE_MEASURE: begin
               e.adc_start = 1'b1;
               if (mask != 0) begin
                  any_fault = 1'b0;
                  for (int ch = 0; ch < CHANNELS; ch++) begin
                     if (mask[ch] && w.sample_ok[ch]) judge_reading(ch, w.volt[ch]);
                     if (status[ch] == ST_OPEN || status[ch] == ST_SHORT) any_fault = 1'b1;
                  end
                  latch      = any_fault;
                  e.adc_mask = mask;
               end
            end
            MODE_RESET_DET: begin
               latch = 1'b0;
               for (int ch = 0; ch < CHANNELS; ch++) begin
                  countdown[ch] = confirm_load;
                  if (status[ch] == ST_OPEN || status[ch] == ST_SHORT) status[ch] = ST_INIT;
               end
            end
            MODE_SLEEP: begin
               apply_duties('0);
               driver = 1'b0;
               for (int ch = 0; ch < CHANNELS; ch++) status[ch] = ST_INIT;
            end
            MODE_INIT: begin
               mask   = '0;
               latch  = 1'b0;
               driver = 1'b1;
               for (int ch = 0; ch < CHANNELS; ch++) begin
                  status[ch]    = ST_INIT;
                  countdown[ch] = confirm_load;
               end
            end
            default: ;
         endcase
         for (int ch = 0; ch < CHANNELS; ch++) begin
            e.duty[ch]  = duty[ch];
            e.state[ch] = status[ch];
         end
         e.detect_mask = mask;
         e.fault_flag  = latch;
         e.driver_on   = driver;
         words_due.push_back(e);
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 40) $display("mismatch at %0t: %s", $time, what);
      endtask

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
      endtask

      task check_status_word(status_word_type got);
         status_word_type e;
         string           color [3];
         color = '{"red", "green", "blue"};
         if (words_due.size() == 0) begin
            report("status word with nothing outstanding");
            return;
         end
         e = words_due.pop_front();
         for (int ch = 0; ch < CHANNELS; ch++) begin
            compare_field({"out_duty_", color[ch]}, got.duty[ch], e.duty[ch]);
            compare_field({"state_", color[ch]}, got.state[ch], e.state[ch]);
         end
         compare_field("detect_mask", got.detect_mask, e.detect_mask);
         compare_field("fault_flag", got.fault_flag, e.fault_flag);
         compare_field("adc_start", got.adc_start, e.adc_start);
         compare_field("adc_mask", got.adc_mask, e.adc_mask);
         compare_field("driver_on", got.driver_on, e.driver_on);
      endtask

      function int outstanding();
         return words_due.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;
   logic [2:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;
   logic         csr_we;
   logic [2:0]   csr_addr;
   logic [15:0]  csr_wdata;

   rgb_monitor_scoreboard sb;
   bit                    tx_pause_on;   // sender inserts random gaps
   bit                    rx_stall_on;   // receiver inserts random stalls
   int                    quiet_cycles;
   status_type            lean [3];      // reading each channel tends toward

   rgb_led_duty_and_fault_monitor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sample both handshakes at the rising edge; results first, since a status
   // word accepted now always belongs to an earlier request
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_status_word(status_word_type'(rsp_tdata));
         if (req_tvalid && req_tready) sb.note_command(req_tuser, req_word_type'(req_tdata));
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // result side: draw a stall per word, then hold ready until one is taken
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = rx_stall_on ? $urandom_range(0, MAX_GAP) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_command(logic [2:0] mode, req_word_type w);
      int pause;
      pause = tx_pause_on ? $urandom_range(0, MAX_GAP) : 0;
      if (pause > 0) begin
         req_tvalid <= 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // hold the request side until every status word has come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.outstanding() != 0);
   endtask

   task automatic write_reg(logic [2:0] addr, logic [15:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      sb.write_register(addr, value);
      @(negedge clock);
   endtask

   // full register set while idle, plus a write the block must ignore
   task automatic configure(logic [15:0] cal, logic [15:0] period, logic [15:0] dmin,
                            logic [15:0] open, logic [15:0] short, logic [15:0] confirm);
      wait_idle();
      write_reg(REG_CAL_MODE, cal);
      write_reg(REG_PWM_PERIOD, period);
      write_reg(REG_DUTY_MIN, dmin);
      write_reg(REG_OPEN_LIMIT, open);
      write_reg(REG_SHORT_LIM, short);
      write_reg(REG_CONFIRM, confirm);
      write_reg($urandom_range(0, 1) ? ADDR_SPARE_LO : ADDR_SPARE_HI,
                16'($urandom_range(0, 65535)));
      csr_we <= 1'b0;
   endtask

   function automatic req_word_type make_word(logic [15:0] dr, logic [15:0] dg,
                                              logic [15:0] db, logic [15:0] vr,
                                              logic [15:0] vg, logic [15:0] vb,
                                              logic [2:0] ok);
      req_word_type w;
      w           = '0;
      w.duty      = {db, dg, dr};
      w.volt      = {vb, vg, vr};
      w.sample_ok = ok;
      return w;
   endfunction

   // mostly legal duties below the period, with clamp and threshold edges
   function automatic logic [15:0] pick_duty();
      case ($urandom_range(0, 9))
         0: return 16'($urandom_range(0, 65535));
         1: return '0;
         2: return '1;
         3: return 16'(int'(sb.duty_min) + int'($urandom_range(0, 2)) - 1);
         4: return sb.period;
         default: return (sb.period == 0) ? '0 : 16'($urandom_range(0, int'(sb.period) - 1));
      endcase
   endfunction

   // readings follow the channel's lean so runs of faults get confirmed
   function automatic logic [15:0] pick_volt(int ch);
      int o;
      int s;
      int k;
      o = sb.open_lim;
      s = sb.short_lim;
      k = $urandom_range(0, 9);
      if (k < 7) begin
         case (lean[ch])
            ST_OPEN:  return 16'(o + int'($urandom_range(0, 300)));
            ST_SHORT: return 16'(s - 1 - int'($urandom_range(0, 300)));
            default:  begin
               if (s < o) return 16'(s + int'($urandom_range(0, o - s - 1)));
               return 16'($urandom_range(0, 65535));
            end
         endcase
      end
      if (k == 7) return 16'(($urandom_range(0, 1) ? o : s) + int'($urandom_range(0, 2)) - 1);
      return 16'($urandom_range(0, 65535));
   endfunction

   initial begin
      req_word_type w;
      logic [2:0]   mode;
      int           pick;
      int           phase;
      int           n;
      int           items;
      int           r_cal;
      int           r_period;
      int           r_short;
      int           r_open;
      int           r_confirm;

      sb          = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = MODE_SET_DUTY;
      csr_we      = 1'b0;
      csr_addr    = REG_CAL_MODE;
      csr_wdata   = '0;
      tx_pause_on = 1'b0;
      rx_stall_on = 1'b1;
      for (int ch = 0; ch < CHANNELS; ch++) lean[ch] = ST_NORMAL;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // default registers: period 2000, min 480, open 6999, short 400, confirm 100
      send_command(MODE_INIT, '0);
      send_command(MODE_SET_DUTY, make_word(0, 0, 0, 0, 0, 0, 3'b111));
      // measure with nothing marked: adc request with an empty channel mask
      send_command(MODE_MEASURE, make_word(0, 0, 0, 16'h7FFF, 16'h8000, 0, 3'b111));
      // everything clamps to period minus one
      send_command(MODE_SET_DUTY, make_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 3'b000));
      // duty equal to the minimum does not mark the channel
      send_command(MODE_SET_DUTY, make_word(480, 481, 1999, 0, 0, 0, 3'b000));
      send_command(MODE_SET_DUTY, make_word(1999, 2000, 481, 0, 0, 0, 3'b000));
      // abnormal readings only count down while confirm is nonzero
      send_command(MODE_MEASURE, make_word(0, 0, 0, 16'h7FFF, 16'h8000, 1000, 3'b111));
      send_command(MODE_MEASURE, make_word(0, 0, 0, 6999, 399, 400, 3'b101));
      send_command(MODE_RESET_DET, '0);
      send_command(MODE_SLEEP, '0);
      for (int m = int'(MODE_SPARE_LO); m <= int'(MODE_SPARE_HI); m++)
         send_command(3'(m), make_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 3'b111));
      send_command(MODE_INIT, '0);

      // confirm of zero: a single abnormal reading sets the fault
      configure(CAL_NONE, 2000, 0, 3000, 1000, 0);
      send_command(MODE_INIT, '0);
      send_command(MODE_SET_DUTY, make_word(100, 200, 300, 0, 0, 0, 3'b000));
      send_command(MODE_MEASURE, make_word(0, 0, 0, 3000, 999, 1000, 3'b111));
      // sleep keeps the fault flag although every status goes back to init
      send_command(MODE_SLEEP, '0);
      send_command(MODE_MEASURE, make_word(0, 0, 0, 5000, 5000, 5000, 3'b111));
      send_command(MODE_SET_DUTY, make_word(100, 200, 300, 0, 0, 0, 3'b000));
      send_command(MODE_MEASURE, make_word(0, 0, 0, 5000, -16'sd5000, 2000, 3'b111));
      send_command(MODE_RESET_DET, '0);

      // calibration override on green only
      configure(CAL_GREEN, 2000, 480, 3000, 1000, 0);
      send_command(MODE_SET_DUTY, make_word(1, 2, 3, 0, 0, 0, 3'b000));
      send_command(MODE_MEASURE, make_word(0, 0, 0, 5000, 5000, 5000, 3'b111));
      // calibration code above four is dropped; zero period forces all duties to zero
      configure(16'h0005, 0, 0, 3000, 1000, 0);
      send_command(MODE_SET_DUTY, make_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 3'b000));
      configure(CAL_BLUE, 16'hFFFF, 0, 3000, 1000, 2);
      send_command(MODE_SET_DUTY, make_word(0, 0, 0, 0, 0, 0, 3'b000));

      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: configure(CAL_LIMIT, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF);
            1: configure(CAL_RED, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000);
            default: begin
               r_cal = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : CAL_NONE;
               case ($urandom_range(0, 7))
                  0:       r_period = 0;
                  1:       r_period = $urandom_range(1, 65535);
                  default: r_period = $urandom_range(100, 4000);
               endcase
               r_short = $urandom_range(0, 1700) - 200;
               // now and then the thresholds cross, open wins there
               if ($urandom_range(0, 5) == 0)
                  r_open = r_short - int'($urandom_range(0, 1000));
               else
                  r_open = r_short + int'($urandom_range(0, 8000));
               case ($urandom_range(0, 9))
                  7:       r_confirm = 100;
                  8:       r_confirm = $urandom_range(0, 65535);
                  9:       r_confirm = 0;
                  default: r_confirm = $urandom_range(0, 4);
               endcase
               configure(16'(r_cal), 16'(r_period), 16'($urandom_range(0, r_period / 2)),
                         16'(r_open), 16'(r_short), 16'(r_confirm));
            end
         endcase
         items = (phase < 2) ? 60 : 250;
         for (n = 0; n < items; n++) begin
            if (n % 40 == 0) begin
               tx_pause_on = $urandom_range(0, 2) != 0;
               rx_stall_on = $urandom_range(0, 2) != 0;
            end
            if (n % 12 == 0) begin
               for (int ch = 0; ch < CHANNELS; ch++)
                  lean[ch] = $urandom_range(0, 1) ? ST_NORMAL :
                             ($urandom_range(0, 1) ? ST_OPEN : ST_SHORT);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
               mode = MODE_MEASURE;
            else if (pick < 75)
               mode = MODE_SET_DUTY;
            else if (pick < 82)
               mode = MODE_RESET_DET;
            else if (pick < 87)
               mode = MODE_SLEEP;
            else if (pick < 94)
               mode = MODE_INIT;
            else
               mode = MODE_SPARE_LO + 3'($urandom_range(0, 2));
            w = '0;
            for (int ch = 0; ch < CHANNELS; ch++) begin
               w.duty[ch]      = pick_duty();
               w.volt[ch]      = pick_volt(ch);
               w.sample_ok[ch] = $urandom_range(0, 4) != 0;
            end
            send_command(mode, w);
         end
      end

      // drain, then watch for any stray word before the verdict
      wait_idle();
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
